FILE: rtl/core/irc_pkg.sv
`default_nettype none
package irc_pkg;

    localparam int DEV_W   = 16;
    localparam int INO_W   = 12;
    localparam int RIDX_W  = 6;
    localparam int CNT_W   = 8;
    localparam int ST_W    = 3;
    localparam int SEC_W   = 17;
    localparam int OFF_W   = 9;
    localparam int IMAP_W  = 8;
    localparam int SMAP_W  = 16;
    localparam int CFG_W   = 16;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic CFG_IMAP = 1'b0;
    localparam logic CFG_SMAP = 1'b1;

    localparam logic [ST_W-1:0] ST_HIT    = 3'd0;
    localparam logic [ST_W-1:0] ST_MISS   = 3'd1;
    localparam logic [ST_W-1:0] ST_NULL   = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd3;
    localparam logic [ST_W-1:0] ST_REL    = 3'd4;
    localparam logic [ST_W-1:0] ST_RELERR = 3'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // search transaction walking along the slot chain
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [DEV_W-1:0]  device;
        logic [INO_W-1:0]  inode;
        logic [RIDX_W-1:0] rel_idx;
        logic              hit;
        logic [CNT_W-1:0]  cnt;
        logic              free;
    } t_tok;

    // write broadcast to one slot
    typedef struct packed {
        logic              we;
        logic              set_key;
        logic [CNT_W-1:0]  cnt;
        logic [DEV_W-1:0]  device;
        logic [INO_W-1:0]  inode;
    } t_upd;

endpackage
`default_nettype wire

FILE: rtl/core/irc_cell.sv
`default_nettype none
module irc_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire irc_pkg::t_tok   i_tok,
    input  wire  [IW-1:0]        i_hit_slot,
    input  wire  [IW-1:0]        i_free_slot,
    output irc_pkg::t_tok        o_tok,
    output logic [IW-1:0]        o_hit_slot,
    output logic [IW-1:0]        o_free_slot,
    input  wire irc_pkg::t_upd   i_upd,
    input  wire  [IW-1:0]        i_upd_slot
);

    logic [irc_pkg::CNT_W-1:0] r_count;
    logic [irc_pkg::DEV_W-1:0] r_device;
    logic [irc_pkg::INO_W-1:0] r_inode;

    irc_pkg::t_tok   n_tok;
    logic [IW-1:0]   n_hit_slot;
    logic [IW-1:0]   n_free_slot;
    logic            live;
    logic            key_match;
    logic            rel_sel;

    assign live      = r_count != '0;
    assign key_match = live && (i_tok.op == irc_pkg::OP_ACQUIRE)
                       && (r_device == i_tok.device) && (r_inode == i_tok.inode);
    assign rel_sel   = live && (i_tok.op == irc_pkg::OP_RELEASE)
                       && (int'(i_tok.rel_idx) == IDX);

    always_comb begin
        n_tok       = i_tok;
        n_hit_slot  = i_hit_slot;
        n_free_slot = i_free_slot;
        if (!i_tok.hit && (key_match || rel_sel)) begin
            n_tok.hit  = 1'b1;
            n_tok.cnt  = r_count;
            n_hit_slot = IW'(IDX);
        end
        if (!i_tok.free && !live) begin
            n_tok.free  = 1'b1;
            n_free_slot = IW'(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tok.valid <= 1'b0;
            r_count     <= '0;
        end else begin
            o_tok.valid <= n_tok.valid;
            if (i_upd.we && (i_upd_slot == IW'(IDX))) begin
                r_count <= i_upd.cnt;
            end
        end
        o_tok.op      <= n_tok.op;
        o_tok.device  <= n_tok.device;
        o_tok.inode   <= n_tok.inode;
        o_tok.rel_idx <= n_tok.rel_idx;
        o_tok.hit     <= n_tok.hit;
        o_tok.cnt     <= n_tok.cnt;
        o_tok.free    <= n_tok.free;
        o_hit_slot    <= n_hit_slot;
        o_free_slot   <= n_free_slot;
        if (i_upd.we && i_upd.set_key && (i_upd_slot == IW'(IDX))) begin
            r_device <= i_upd.device;
            r_inode  <= i_upd.inode;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/inode_reference_cache_unit.sv
// inode reference cache: slot table of open inode keys with reference counts
// input channel: i_valid / o_stall carry one request (operation, device,
//   inode_number, slot_index); a request is taken when i_valid is high and
//   o_stall is low
// output channel: o_valid / i_stall carry one result per request (status,
//   slot, ref_count, load_sector, load_offset)
// config port: i_cfg_we with i_cfg_index 0 writes imap_sectors, 1 writes
//   smap_sectors; write only while no request is in flight
// the request walks a chain of SLOTS slot cells, one cell per cycle, picking
//   up the first key match (or release target) and the lowest free slot
// latency: o_valid rises SLOTS + 2 cycles after the accepting edge
// throughput: one request at a time, about SLOTS + 4 cycles per transaction,
//   set by the walk through the cell chain
// reset: all slots free, imap_sectors and smap_sectors at 1, no result pending
// a stalled result holds on the outputs and o_stall stays high until taken
`default_nettype none
module inode_reference_cache_unit #(
    parameter int SLOTS        = 64,
    parameter int SECTOR_BYTES = 512,
    parameter int INODE_BYTES  = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire                           i_operation,
    input  wire  [irc_pkg::DEV_W-1:0]     i_device,
    input  wire  [irc_pkg::INO_W-1:0]     i_inode_number,
    input  wire  [irc_pkg::RIDX_W-1:0]    i_slot_index,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic [irc_pkg::ST_W-1:0]      o_status,
    output logic [irc_pkg::RIDX_W-1:0]    o_slot,
    output logic [irc_pkg::CNT_W-1:0]     o_ref_count,
    output logic [irc_pkg::SEC_W-1:0]     o_load_sector,
    output logic [irc_pkg::OFF_W-1:0]     o_load_offset,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_index,
    input  wire  [irc_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int IW       = $clog2(SLOTS);
    localparam int PER_RAW  = SECTOR_BYTES / INODE_BYTES;
    localparam int PER      = (PER_RAW < 1) ? 1 : PER_RAW;
    localparam int RCP_SH   = 24;
    localparam int RCP      = (1 << RCP_SH) / PER;
    localparam int PROD_W   = irc_pkg::INO_W + RCP_SH;
    localparam int REM_W    = 24;
    localparam int R_W      = 10;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIX  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                    r_state;
    irc_pkg::t_tok                 r_tok_in;
    logic [irc_pkg::INO_W-1:0]     r_q0;
    irc_pkg::t_tok                 r_end;
    logic [IW-1:0]                 r_end_hit_slot;
    logic [IW-1:0]                 r_end_free_slot;
    logic [irc_pkg::INO_W-1:0]     r_q;
    logic [R_W-1:0]                r_r;
    irc_pkg::t_upd                 r_upd;
    logic [IW-1:0]                 r_upd_slot;
    logic [irc_pkg::IMAP_W-1:0]    r_imap;
    logic [irc_pkg::SMAP_W-1:0]    r_smap;

    irc_pkg::t_tok                 tok_chain  [0:SLOTS];
    logic [IW-1:0]                 hit_chain  [0:SLOTS];
    logic [IW-1:0]                 free_chain [0:SLOTS];

    logic                          accept;
    logic [irc_pkg::INO_W-1:0]     in_k;
    logic [PROD_W-1:0]             in_prod;
    logic [irc_pkg::INO_W-1:0]     end_k;
    logic [REM_W-1:0]              rem0;
    logic                          rem_fix;
    logic [31:0]                   off_full;
    logic [irc_pkg::CNT_W-1:0]     inc_cnt;

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_state == S_OUT;
    assign accept  = i_valid && !o_stall;

    assign in_k    = i_inode_number - irc_pkg::INO_W'(1);
    assign in_prod = PROD_W'(in_k) * PROD_W'(RCP);

    assign end_k   = tok_chain[SLOTS].inode - irc_pkg::INO_W'(1);
    assign rem0    = REM_W'(end_k) - REM_W'(r_q0) * REM_W'(PER);
    assign rem_fix = rem0 >= REM_W'(PER);

    assign off_full = 32'(r_r) * 32'(INODE_BYTES);
    assign inc_cnt  = (r_end.cnt == irc_pkg::CNT_MAX) ? r_end.cnt
                      : r_end.cnt + irc_pkg::CNT_W'(1);

    assign tok_chain[0]  = r_tok_in;
    assign hit_chain[0]  = '0;
    assign free_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            irc_cell #(
                .IW  (IW),
                .IDX (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_tok       (tok_chain[g]),
                .i_hit_slot  (hit_chain[g]),
                .i_free_slot (free_chain[g]),
                .o_tok       (tok_chain[g+1]),
                .o_hit_slot  (hit_chain[g+1]),
                .o_free_slot (free_chain[g+1]),
                .i_upd       (r_upd),
                .i_upd_slot  (r_upd_slot)
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_tok_in.valid <= 1'b0;
            r_upd.we       <= 1'b0;
            r_imap         <= irc_pkg::IMAP_W'(1);
            r_smap         <= irc_pkg::SMAP_W'(1);
        end else begin
            r_tok_in.valid <= accept;
            r_upd.we       <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    irc_pkg::CFG_IMAP: r_imap <= i_cfg_data[irc_pkg::IMAP_W-1:0];
                    irc_pkg::CFG_SMAP: r_smap <= i_cfg_data[irc_pkg::SMAP_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (tok_chain[SLOTS].valid) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_state <= S_OUT;
                    if (r_end.op == irc_pkg::OP_RELEASE) begin
                        r_upd.we <= r_end.hit;
                    end else if (r_end.inode != '0) begin
                        r_upd.we <= r_end.hit || r_end.free;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (accept) begin
            r_tok_in.op      <= i_operation;
            r_tok_in.device  <= i_device;
            r_tok_in.inode   <= i_inode_number;
            r_tok_in.rel_idx <= i_slot_index;
            r_tok_in.hit     <= 1'b0;
            r_tok_in.cnt     <= '0;
            r_tok_in.free    <= 1'b0;
            r_q0             <= in_prod[PROD_W-1:RCP_SH];
        end
        if (r_state == S_WALK && tok_chain[SLOTS].valid) begin
            r_end           <= tok_chain[SLOTS];
            r_end_hit_slot  <= hit_chain[SLOTS];
            r_end_free_slot <= free_chain[SLOTS];
            if (rem_fix) begin
                r_q <= r_q0 + irc_pkg::INO_W'(1);
                r_r <= R_W'(rem0 - REM_W'(PER));
            end else begin
                r_q <= r_q0;
                r_r <= R_W'(rem0);
            end
        end
        if (r_state == S_FIX) begin
            o_load_sector <= '0;
            o_load_offset <= '0;
            r_upd.set_key <= 1'b0;
            r_upd.device  <= r_end.device;
            r_upd.inode   <= r_end.inode;
            r_upd.cnt     <= '0;
            r_upd_slot    <= r_end_hit_slot;
            if (r_end.op == irc_pkg::OP_RELEASE) begin
                o_slot <= r_end.rel_idx;
                if (r_end.hit) begin
                    o_status    <= irc_pkg::ST_REL;
                    o_ref_count <= r_end.cnt - irc_pkg::CNT_W'(1);
                    r_upd.cnt   <= r_end.cnt - irc_pkg::CNT_W'(1);
                end else begin
                    o_status    <= irc_pkg::ST_RELERR;
                    o_ref_count <= '0;
                end
            end else if (r_end.inode == '0) begin
                o_status    <= irc_pkg::ST_NULL;
                o_slot      <= '0;
                o_ref_count <= '0;
            end else if (r_end.hit) begin
                o_status    <= irc_pkg::ST_HIT;
                o_slot      <= irc_pkg::RIDX_W'(r_end_hit_slot);
                o_ref_count <= inc_cnt;
                r_upd.cnt   <= inc_cnt;
            end else if (r_end.free) begin
                o_status      <= irc_pkg::ST_MISS;
                o_slot        <= irc_pkg::RIDX_W'(r_end_free_slot);
                o_ref_count   <= irc_pkg::CNT_W'(1);
                o_load_sector <= irc_pkg::SEC_W'(2) + irc_pkg::SEC_W'(r_imap)
                                 + irc_pkg::SEC_W'(r_smap) + irc_pkg::SEC_W'(r_q);
                o_load_offset <= off_full[irc_pkg::OFF_W-1:0];
                r_upd.set_key <= 1'b1;
                r_upd.cnt     <= irc_pkg::CNT_W'(1);
                r_upd_slot    <= r_end_free_slot;
            end else begin
                o_status    <= irc_pkg::ST_FULL;
                o_slot      <= '0;
                o_ref_count <= '0;
            end
        end
    end

endmodule
`default_nettype wire
